### hdl/terminal_key_escape_decoder_defines.svh
// ---------------------------------------------------------------------------
// Terminal key escape decoder: assertion macros
// Shared property wrappers for the checker, clocked on clk_i, off in reset.
// ---------------------------------------------------------------------------
`ifndef TERMINAL_KEY_ESCAPE_DECODER_DEFINES_SVH
`define TERMINAL_KEY_ESCAPE_DECODER_DEFINES_SVH

// same-cycle implication
`define TKED_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TKED_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/tked_pkg.sv
// ---------------------------------------------------------------------------
// Terminal key escape decoder package
// Result type, status codes and character constants.
// ---------------------------------------------------------------------------
package tked_pkg;

  typedef enum logic [1:0] {
    ST_PENDING = 2'd0,
    ST_KEY     = 2'd1,
    ST_ERROR   = 2'd2
  } status_e;

  localparam logic [7:0] CH_ESC   = 8'h1B;
  localparam logic [7:0] CH_LBR   = 8'h5B;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_TILDE = 8'h7E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam int unsigned DataW = 16;
  localparam int unsigned UserW = 8;

  typedef struct packed {
    logic       mod_meta;
    logic       mod_ctrl;
    logic       mod_alt;
    logic       mod_shift;
    logic       is_keycode;
    logic [7:0] key_value;
    status_e    status;
  } result_t;

endpackage

### hdl/terminal_key_escape_decoder.sv
// ---------------------------------------------------------------------------
// Terminal key escape decoder
// Decodes plain keys and ESC [ control sequences from a terminal byte stream.
// ---------------------------------------------------------------------------
// Usage:
//   Input stream s_axis carries one raw terminal byte per item in tdata.
//   Output stream m_axis gives exactly one result item per input byte:
//   tuser holds the status (pending, key ready, error) and the keycode flag,
//   tdata the key value and the four modifier bits.
//   Path: an accepted byte passes through the input register, then the
//   result register, and shows on m_axis once the result register is free.
//   Throughput: one item per cycle while the receiver is ready; the decode
//   is a single pass through the parse core between the two registers, and
//   sequence state updates as the item moves into the result register.
//   Stall: while m_axis_tready is low the result holds, one more byte may
//   wait in the input register, and s_axis_tready drops after that.
//   Reset: both registers empty, parser back at its start state with both
//   numbers cleared.
// ---------------------------------------------------------------------------
module terminal_key_escape_decoder (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,   // [7:0] in_byte
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [7:0] key_value, [8] mod_shift, [9] mod_alt, [10] mod_ctrl, [11] mod_meta
  output logic [tked_pkg::DataW-1:0]    m_axis_tdata,
  // [1:0] status, [2] is_keycode
  output logic [tked_pkg::UserW-1:0]    m_axis_tuser
);
  import tked_pkg::*;

  logic       in_vld_q;
  logic [7:0] in_byte_q;
  logic       out_vld_q;
  result_t    out_q;
  result_t    core_res;
  logic       out_free;
  logic       step;

  assign out_free      = !out_vld_q || m_axis_tready;
  assign step          = in_vld_q && out_free;
  assign s_axis_tready = !in_vld_q || step;

  tked_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .byte_i   (in_byte_q),
    .result_o (core_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_vld_q <= s_axis_tvalid;
      end
      if (out_free) begin
        out_vld_q <= in_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte_q <= s_axis_tdata;
    end
    if (step) begin
      out_q <= core_res;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {4'd0, out_q.mod_meta, out_q.mod_ctrl, out_q.mod_alt,
                          out_q.mod_shift, out_q.key_value};
  assign m_axis_tuser  = {5'd0, out_q.is_keycode, out_q.status};

endmodule

### hdl/tked_core.sv
// ---------------------------------------------------------------------------
// Terminal key escape decoder: parse core
// Sequence state and the per-byte decode; state moves on step_i.
// ---------------------------------------------------------------------------
module tked_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            step_i,
  input  logic [7:0]      byte_i,
  output tked_pkg::result_t result_o
);
  import tked_pkg::*;

  localparam logic [1:0] PH_START = 2'd0;
  localparam logic [1:0] PH_ESC   = 2'd1;
  localparam logic [1:0] PH_NUM1  = 2'd2;
  localparam logic [1:0] PH_NUM2  = 2'd3;

  logic [1:0] phase_q, phase_d;
  logic [7:0] num1_q, num1_d;
  logic [7:0] num2_q, num2_d;
  logic       digit;
  logic [7:0] digit_val;
  logic [7:0] num1_step, num2_step;
  logic [7:0] num1_fix, num2_fix;
  logic [7:0] mods_raw;
  result_t    res;

  assign digit     = (byte_i >= CH_ZERO) && (byte_i <= CH_NINE);
  assign digit_val = byte_i - CH_ZERO;
  // n*10 + d, wrapping at 8 bits
  assign num1_step = (num1_q << 3) + (num1_q << 1) + digit_val;
  assign num2_step = (num2_q << 3) + (num2_q << 1) + digit_val;
  assign num1_fix  = (num1_q == 8'd0) ? 8'd1 : num1_q;
  assign num2_fix  = (num2_q == 8'd0) ? 8'd1 : num2_q;

  always_comb begin
    phase_d  = phase_q;
    num1_d   = num1_q;
    num2_d   = num2_q;
    mods_raw = 8'd1;
    res      = '0;
    res.status = ST_PENDING;
    unique case (phase_q)
      PH_START: begin
        if (byte_i == CH_ESC) begin
          phase_d = PH_ESC;
        end else begin
          res.status    = ST_KEY;
          res.key_value = byte_i;
        end
      end
      PH_ESC: begin
        if (byte_i == CH_ESC) begin
          phase_d       = PH_START;
          res.status    = ST_KEY;
          res.key_value = CH_ESC;
        end else if (byte_i == CH_LBR) begin
          phase_d = PH_NUM1;
          num1_d  = 8'd0;
        end else begin
          phase_d    = PH_START;
          res.status = ST_ERROR;
        end
      end
      PH_NUM1: begin
        if (digit) begin
          num1_d = num1_step;
        end else begin
          num1_d = num1_fix;
          priority if (byte_i == CH_SEMI) begin
            phase_d = PH_NUM2;
            num2_d  = 8'd0;
          end else if (byte_i == CH_TILDE) begin
            phase_d        = PH_START;
            res.status     = ST_KEY;
            res.key_value  = num1_fix;
            res.is_keycode = 1'b1;
          end else begin
            phase_d        = PH_START;
            res.status     = ST_KEY;
            res.key_value  = byte_i;
            res.is_keycode = 1'b1;
            mods_raw       = num1_fix;
          end
        end
      end
      PH_NUM2: begin
        if (digit) begin
          num2_d = num2_step;
        end else if (byte_i == CH_TILDE) begin
          phase_d        = PH_START;
          num2_d         = num2_fix;
          res.status     = ST_KEY;
          res.key_value  = num1_q;
          res.is_keycode = 1'b1;
          mods_raw       = num2_fix;
        end else begin
          phase_d    = PH_START;
          res.status = ST_ERROR;
        end
      end
      default: begin
        phase_d = PH_START;
      end
    endcase
    // modifier value is number minus one; mods_raw defaults to 1, giving none
    {res.mod_meta, res.mod_ctrl, res.mod_alt, res.mod_shift} = 4'(mods_raw - 8'd1);
  end

  assign result_o = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_START;
      num1_q  <= 8'd0;
      num2_q  <= 8'd0;
    end else if (step_i) begin
      phase_q <= phase_d;
      num1_q  <= num1_d;
      num2_q  <= num2_d;
    end
  end

endmodule

### hdl/tked_checker.sv
// ---------------------------------------------------------------------------
// Terminal key escape decoder checker
// Port-level properties of the result stream; bound to the top level.
// ---------------------------------------------------------------------------
`include "terminal_key_escape_decoder_defines.svh"

module tked_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       m_axis_tvalid,
  input logic                       m_axis_tready,
  input logic [tked_pkg::DataW-1:0] m_axis_tdata,
  input logic [tked_pkg::UserW-1:0] m_axis_tuser
);
  import tked_pkg::*;

  logic       out_stall;
  logic       out_key;
  logic       out_plain;

  assign out_stall = m_axis_tvalid && !m_axis_tready;
  assign out_key   = m_axis_tvalid && (m_axis_tuser[1:0] == ST_KEY);
  assign out_plain = out_key && !m_axis_tuser[2];

  // stalled result holds
  `TKED_ASSERT_NEXT(a_out_hold, out_stall,
    m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser),
    "result changed while stalled")

  `TKED_ASSERT_NOW(a_status_code, m_axis_tvalid,
    m_axis_tuser[1:0] == ST_PENDING || m_axis_tuser[1:0] == ST_KEY ||
    m_axis_tuser[1:0] == ST_ERROR,
    "status outside its codes")

  // pending and error items carry nothing
  `TKED_ASSERT_NOW(a_idle_payload, m_axis_tvalid && !out_key,
    m_axis_tdata == '0 && m_axis_tuser[UserW-1:2] == '0,
    "payload on a non-key result")

  // a plain key never carries modifiers
  `TKED_ASSERT_NOW(a_plain_no_mods, out_plain,
    m_axis_tdata[DataW-1:8] == '0,
    "modifiers on a plain key")

endmodule

bind terminal_key_escape_decoder tked_checker u_tked_checker (.*);

### verif/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Terminal key escape decoder testbench
// Streams plain bytes and ESC [ sequences, both well formed and broken,
// through the decoder under random back-pressure. Every result item is
// checked against a cycle-free decode of the same byte stream.
// ---------------------------------------------------------------------------
module testbench;
  import tked_pkg::*;

  typedef enum logic [1:0] {
    SEQ_TEXT    = 2'd0,
    SEQ_ESCAPED = 2'd1,
    SEQ_FIRST   = 2'd2,
    SEQ_SECOND  = 2'd3
  } seq_phase_e;

  localparam int unsigned RandomItems = 450;
  localparam int unsigned HoldCycles  = 250;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [7:0]          s_axis_tdata  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [DataW-1:0]    m_axis_tdata;
  logic [UserW-1:0]    m_axis_tuser;

  logic [7:0]          byte_queue[$];
  result_t             expected_keys[$];

  // decoder state as seen by the predictor
  seq_phase_e          seq_phase  = SEQ_TEXT;
  logic [7:0]          num_first  = '0;
  logic [7:0]          num_second = '0;

  int                  tx_idle_pct = 34;
  int                  rx_idle_pct = 34;
  int                  hold_req    = 0;
  int                  hold_seen   = 0;
  int                  hold_left   = 0;
  int                  items_pushed = 0;
  int                  fail_count  = 0;

  terminal_key_escape_decoder dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  // modifier bits {meta, ctrl, alt, shift} from (n - 1) mod 256
  function automatic logic [3:0] mods_from(logic [7:0] n);
    logic [7:0] m;
    m = n - 8'd1;
    return m[3:0];
  endfunction

  function automatic result_t decode_key_byte(logic [7:0] b);
    result_t r;
    logic    is_digit;
    r = '0;
    is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
    case (seq_phase)
      SEQ_TEXT: begin
        if (b == CH_ESC) begin
          seq_phase = SEQ_ESCAPED;
        end else begin
          r.status    = ST_KEY;
          r.key_value = b;
        end
      end
      SEQ_ESCAPED: begin
        if (b == CH_ESC) begin
          seq_phase   = SEQ_TEXT;
          r.status    = ST_KEY;
          r.key_value = CH_ESC;
        end else if (b == CH_LBR) begin
          seq_phase = SEQ_FIRST;
          num_first = '0;
        end else begin
          seq_phase = SEQ_TEXT;
          r.status  = ST_ERROR;
        end
      end
      SEQ_FIRST: begin
        if (is_digit) begin
          num_first = num_first * 8'd10 + (b - CH_ZERO);
        end else begin
          if (num_first == 8'd0) num_first = 8'd1;
          if (b == CH_SEMI) begin
            seq_phase  = SEQ_SECOND;
            num_second = '0;
          end else if (b == CH_TILDE) begin
            seq_phase    = SEQ_TEXT;
            r.status     = ST_KEY;
            r.key_value  = num_first;
            r.is_keycode = 1'b1;
          end else begin
            seq_phase    = SEQ_TEXT;
            r.status     = ST_KEY;
            r.key_value  = b;
            r.is_keycode = 1'b1;
            {r.mod_meta, r.mod_ctrl, r.mod_alt, r.mod_shift} = mods_from(num_first);
          end
        end
      end
      default: begin
        if (is_digit) begin
          num_second = num_second * 8'd10 + (b - CH_ZERO);
        end else if (b == CH_TILDE) begin
          seq_phase = SEQ_TEXT;
          if (num_second == 8'd0) num_second = 8'd1;
          r.status     = ST_KEY;
          r.key_value  = num_first;
          r.is_keycode = 1'b1;
          {r.mod_meta, r.mod_ctrl, r.mod_alt, r.mod_shift} = mods_from(num_second);
        end else begin
          seq_phase = SEQ_TEXT;
          r.status  = ST_ERROR;
        end
      end
    endcase
    return r;
  endfunction

  // sender: predicts on acceptance, then offers the next queued item
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_keys.push_back(decode_key_byte(s_axis_tdata));
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (byte_queue.size() > 0 && $urandom_range(99, 0) >= tx_idle_pct) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= byte_queue.pop_front();
        end else begin
          s_axis_tvalid <= 1'b0;
          s_axis_tdata  <= 8'($urandom);
        end
      end
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (hold_seen != hold_req) begin
        hold_seen = hold_req;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left     = hold_left - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99, 0) >= rx_idle_pct);
      end
    end
  end

  task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk_i) begin : result_monitor
    result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_keys.size() == 0) begin
        $error("result item with nothing expected: tuser %0h tdata %0h",
               m_axis_tuser, m_axis_tdata);
        fail_count++;
      end else begin
        want = expected_keys.pop_front();
        check_field("status",     8'(want.status),     8'(m_axis_tuser[1:0]));
        check_field("is_keycode", 8'(want.is_keycode), 8'(m_axis_tuser[2]));
        check_field("key_value",  want.key_value,      m_axis_tdata[7:0]);
        check_field("mod_shift",  8'(want.mod_shift),  8'(m_axis_tdata[8]));
        check_field("mod_alt",    8'(want.mod_alt),    8'(m_axis_tdata[9]));
        check_field("mod_ctrl",   8'(want.mod_ctrl),   8'(m_axis_tdata[10]));
        check_field("mod_meta",   8'(want.mod_meta),   8'(m_axis_tdata[11]));
      end
    end
  end

  task automatic push_item(logic [7:0] b);
    byte_queue.push_back(b);
    items_pushed++;
  endtask

  task automatic push_digits(int unsigned count);
    for (int unsigned i = 0; i < count; i++) begin
      push_item(CH_ZERO + 8'($urandom_range(9, 0)));
    end
  endtask

  // mostly well-formed sequences, with some noise and broken endings
  task automatic push_random_sequence();
    int unsigned kind;
    kind = $urandom_range(9, 0);
    if (kind == 0) begin
      push_item(8'($urandom));
    end else if (kind == 1) begin
      push_item(CH_ESC);
      push_item(CH_ESC);
    end else if (kind == 2) begin
      push_item(CH_ESC);
      push_item(8'($urandom));
    end else begin
      push_item(CH_ESC);
      push_item(CH_LBR);
      push_digits($urandom_range(4, 0));
      case (kind)
        3, 4: push_item(CH_TILDE);
        5, 6: begin
          push_item(CH_SEMI);
          push_digits($urandom_range(4, 0));
          push_item(CH_TILDE);
        end
        7, 8: push_item(8'($urandom_range(8'h7D, 8'h40)));
        default: begin
          push_item(CH_SEMI);
          push_digits($urandom_range(4, 0));
          push_item(8'($urandom));
        end
      endcase
    end
  endtask

  task automatic push_random_items(int unsigned count);
    int unsigned stop_at;
    stop_at = items_pushed + count;
    while (items_pushed < stop_at) push_random_sequence();
  endtask

  task automatic wait_drained();
    do @(posedge clk_i);
    while (byte_queue.size() != 0 || s_axis_tvalid || expected_keys.size() != 0);
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: field extremes, ESC ESC, bad escape, zero and overflowing
    // numbers, modifiers from either number, broken second number
    push_item(8'h00);
    push_item(8'hFF);
    push_item(CH_ESC);   push_item(CH_ESC);
    push_item(CH_ESC);   push_item("q");
    push_item(CH_ESC);   push_item(CH_LBR);  push_item(CH_TILDE);
    push_item(CH_ESC);   push_item(CH_LBR);
    push_item("3");      push_item("0");     push_item("0");   push_item(CH_TILDE);
    push_item(CH_ESC);   push_item(CH_LBR);
    push_item(CH_SEMI);  push_item("9");     push_item(CH_TILDE);
    push_item(CH_ESC);   push_item(CH_LBR);  push_item("7");   push_item("A");
    push_item(CH_ESC);   push_item(CH_LBR);  push_item("2");
    push_item(CH_SEMI);  push_item("Z");
    // sender pauses here until every result is back
    wait_drained();

    push_random_items(RandomItems / 3);
    wait_drained();

    // long stretch without any idling on either side
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    push_random_items(RandomItems / 3);
    wait_drained();

    // receiver holds off while the sender keeps offering
    rx_idle_pct = 34;
    hold_req    = hold_req + 1;
    push_random_items(RandomItems / 3);
    wait_drained();

    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

### filelist.f
+incdir+hdl
hdl/tked_pkg.sv
hdl/tked_core.sv
hdl/terminal_key_escape_decoder.sv
hdl/tked_checker.sv
verif/testbench.sv
